// ----- rtl/mmo_pkg.sv -----
// Shared types and constants for the MIDI message outbox.
`timescale 1ns / 1ps
package mmo_pkg;

	// Operation codes of an input request
	localparam logic OP_QUEUE = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_ANSWER  = 2'd0;
	localparam logic [1:0] KIND_DRAINED = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;

	// Message lengths: FULL_LENGTH carries a second data byte, SHORT_LENGTH does not
	localparam logic [1:0] FULL_LENGTH = 2'd3;
	localparam logic [1:0] SHORT_LENGTH = 2'd2;

	// Results one drain may emit, and the width of its counter
	localparam int MAX_RESULTS = 16;
	localparam int NEMIT_W = 4;

	// Configuration register indexes
	localparam logic REG_CHANNEL = 1'b0;

	typedef struct packed {
		logic       operation;
		logic [7:0] status_byte;
		logic [7:0] first_data;
		logic [7:0] second_data;
		logic [1:0] message_length;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       accepted;
		logic [7:0] out_status;
		logic [7:0] out_first;
		logic [7:0] out_second;
		logic [1:0] out_length;
		logic [3:0] frame_offset;
		logic       last;
	} out_item_t;

	// One stored message
	typedef struct packed {
		logic [7:0] status;
		logic [7:0] first;
		logic [7:0] second;
		logic [1:0] length;
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic store;
		logic read;
		logic emit_answer;
		logic emit_drain;
		logic emit_none;
		logic acc;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op;
		logic cur_pend;
		logic at_end;
		logic match;
		logic cnt_zero;
		logic drain_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/mmo_dp.sv -----
// Datapath of the MIDI message outbox: slot memory, pending bits, scan index, output register.
`timescale 1ns / 1ps
module mmo_dp #(
	parameter int SLOT_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mmo_pkg::dp_cmd_t   cmd,
	output mmo_pkg::dp_stat_t  stat,
	input  mmo_pkg::in_item_t  in_data,
	input  logic [3:0]         channel,
	output logic               out_valid,
	input  logic               out_stall,
	output mmo_pkg::out_item_t out_data
);
	import mmo_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);

	logic                  op_q;
	slot_t                 req_q;
	slot_t                 rd_q;
	slot_t                 mem [SLOT_COUNT];
	logic [IDX_W-1:0]      idx_q;
	logic [SLOT_COUNT-1:0] pend_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NEMIT_W-1:0]    nemit_q;
	logic                  out_valid_q;
	out_item_t             out_q;
	logic                  three;

	// Capture the request with the channel ORed into the status byte
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= in_data.operation;
			req_q.status <= in_data.status_byte | {4'd0, channel};
			req_q.first  <= in_data.first_data;
			req_q.second <= in_data.second_data;
			req_q.length <= in_data.message_length;
		end
	end

	// Slot memory: write at the scan index, registered read
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[idx_q] <= req_q;
		end
		if (cmd.read) begin
			rd_q <= mem[idx_q];
		end
	end

	// Scan index, pending bits, pending count, drain result count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pend_q  <= '0;
			cnt_q   <= '0;
			nemit_q <= '0;
		end else begin
			if (cmd.idx_clr) begin
				idx_q   <= '0;
				nemit_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.store) begin
				pend_q[idx_q] <= 1'b1;
				cnt_q         <= cnt_q + CNT_W'(1);
			end else if (cmd.emit_drain) begin
				pend_q[idx_q] <= 1'b0;
				cnt_q         <= cnt_q - CNT_W'(1);
				nemit_q       <= nemit_q + NEMIT_W'(1);
			end
		end
	end

	assign three = (rd_q.length == FULL_LENGTH);

	// Output register: load a result when empty or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_answer || cmd.emit_drain || cmd.emit_none) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_answer) begin
			out_q          <= '0;
			out_q.kind     <= KIND_ANSWER;
			out_q.accepted <= cmd.acc;
			out_q.last     <= 1'b1;
		end else if (cmd.emit_none) begin
			out_q      <= '0;
			out_q.kind <= KIND_NONE;
			out_q.last <= 1'b1;
		end else if (cmd.emit_drain) begin
			out_q.kind         <= KIND_DRAINED;
			out_q.accepted     <= 1'b0;
			out_q.out_status   <= rd_q.status;
			out_q.out_first    <= rd_q.first;
			out_q.out_second   <= three ? rd_q.second : 8'd0;
			out_q.out_length   <= three ? FULL_LENGTH : SHORT_LENGTH;
			out_q.frame_offset <= 4'(idx_q);
			out_q.last         <= stat.drain_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Status toward the controller
	assign stat.op         = op_q;
	assign stat.cur_pend   = pend_q[idx_q];
	assign stat.at_end     = (idx_q == IDX_W'(SLOT_COUNT - 1));
	assign stat.match      = (rd_q == req_q);
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.drain_last = (cnt_q == CNT_W'(1)) || (nemit_q == NEMIT_W'(MAX_RESULTS - 1));
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

// ----- rtl/mmo_ctrl.sv -----
// Controller of the MIDI message outbox: sequences the slot scan for queue and drain requests.
`timescale 1ns / 1ps
module mmo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mmo_pkg::dp_stat_t stat,
	output mmo_pkg::dp_cmd_t  cmd
);
	import mmo_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CMP,
		ST_EMIT,
		ST_RESULT
	} state_t;

	state_t state_q;
	logic   none_q;
	logic   acc_q;

	assign in_stall = (state_q != ST_IDLE);

	// Decode commands from the state and the datapath status
	always_comb begin
		cmd         = '0;
		cmd.acc     = acc_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load    = in_valid;
				cmd.idx_clr = in_valid;
			end
			ST_SCAN: begin
				if (stat.op == OP_QUEUE) begin
					cmd.store = !stat.cur_pend;
					cmd.read  = stat.cur_pend;
				end else if (!stat.cnt_zero) begin
					cmd.read    = stat.cur_pend;
					cmd.idx_inc = !stat.cur_pend;
				end
			end
			ST_CMP: begin
				cmd.idx_inc = !stat.match && !stat.at_end;
			end
			ST_EMIT: begin
				cmd.emit_drain = stat.out_free;
				cmd.idx_inc    = stat.out_free && !stat.drain_last;
			end
			ST_RESULT: begin
				cmd.emit_answer = stat.out_free && !none_q;
				cmd.emit_none   = stat.out_free && none_q;
			end
			default: begin
			end
		endcase
	end

	// Hold state and the pending answer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			none_q  <= 1'b0;
			acc_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.op == OP_QUEUE) begin
						if (!stat.cur_pend) begin
							none_q  <= 1'b0;
							acc_q   <= 1'b1;
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_CMP;
						end
					end else if (stat.cnt_zero) begin
						none_q  <= 1'b1;
						acc_q   <= 1'b0;
						state_q <= ST_RESULT;
					end else if (stat.cur_pend) begin
						state_q <= ST_EMIT;
					end
				end
				ST_CMP: begin
					if (stat.match || stat.at_end) begin
						none_q  <= 1'b0;
						acc_q   <= stat.match;
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						state_q <= stat.drain_last ? ST_IDLE : ST_SCAN;
					end
				end
				ST_RESULT: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/midi_message_outbox.sv -----
// Top level of the MIDI message outbox: configuration register, controller and datapath.
`timescale 1ns / 1ps
// Pending-message table for MIDI output with SLOT_COUNT slots. A queue request
// ORs the channel register into the status byte, then scans the slots from
// index 0 one per step: a free slot stores the message, an occupied slot with
// the same message accepts it as a duplicate, and running off the end rejects
// it; one answer result follows. Each occupied slot that a queue request passes
// costs one registered read of the slot memory and one compare.
// A drain request emits every pending slot in index order (at most 16 per
// request, the rest stay pending), with the slot index as frame offset and
// last set on the final one, or a single empty result when nothing is
// pending. A result that finds the output register full waits while it is
// stalled. The next request is taken only after the last result is loaded
// and the controller is back in idle. The result sits in an output register,
// so a new request is taken while the previous result waits. The channel
// register lies at byte address 0.
module midi_message_outbox #(
	parameter int SLOT_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mmo_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mmo_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import mmo_pkg::*;

	logic [3:0] channel_q;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	assign pready = 1'b1;

	// Write the channel register; byte lanes in paddr[1:0] are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= 4'd0;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL)) begin
			channel_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_CHANNEL) ? {28'd0, channel_q} : 32'd0;

	mmo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	mmo_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.channel   (channel_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- verif/mmo_checker.sv -----
// Result checker for the MIDI message outbox: watches both channels and the register port.
`timescale 1ns / 1ps
module mmo_checker #(
	parameter int SLOT_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  mmo_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  mmo_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 outstanding
);
	import mmo_pkg::*;

	localparam logic [2:0] CHANNEL_ADDR = {REG_CHANNEL, 2'b00};

	logic [3:0] channel;
	slot_t      slot_msg [SLOT_COUNT];
	logic       slot_busy [SLOT_COUNT];
	out_item_t  expected_replies [$];

	initial begin
		channel = '0;
		fail_count = 0;
		outstanding = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			slot_busy[i] = 1'b0;
			slot_msg[i] = '0;
		end
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	// Advance the slot table by one request and queue the replies it must produce
	task automatic predict_request(input in_item_t req);
		slot_t     msg;
		out_item_t reply;
		logic      taken;
		logic      settled;
		int        emitted;
		int        tail_slot;
		reply = '0;
		if (req.operation == OP_QUEUE) begin
			msg.status = req.status_byte | {4'h0, channel};
			msg.first  = req.first_data;
			msg.second = req.second_data;
			msg.length = req.message_length;
			taken = 1'b0;
			settled = 1'b0;
			// scan upward: a matching busy slot or the first free slot ends the search
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (!settled) begin
					if (slot_busy[i]) begin
						if (slot_msg[i] == msg) begin
							taken = 1'b1;
							settled = 1'b1;
						end
					end else begin
						slot_msg[i] = msg;
						slot_busy[i] = 1'b1;
						taken = 1'b1;
						settled = 1'b1;
					end
				end
			end
			reply.kind = KIND_ANSWER;
			reply.accepted = taken;
			reply.last = 1'b1;
			expected_replies.push_back(reply);
		end else begin
			// find the highest slot this drain will emit
			emitted = 0;
			tail_slot = -1;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot_busy[i] && emitted < MAX_RESULTS) begin
					tail_slot = i;
					emitted++;
				end
			end
			if (tail_slot < 0) begin
				reply.kind = KIND_NONE;
				reply.last = 1'b1;
				expected_replies.push_back(reply);
			end else begin
				for (int i = 0; i <= tail_slot; i++) begin
					if (slot_busy[i]) begin
						reply = '0;
						reply.kind = KIND_DRAINED;
						reply.out_status = slot_msg[i].status;
						reply.out_first = slot_msg[i].first;
						// anything but a full length goes out as a two-byte message
						if (slot_msg[i].length == FULL_LENGTH) begin
							reply.out_second = slot_msg[i].second;
							reply.out_length = FULL_LENGTH;
						end else begin
							reply.out_length = SHORT_LENGTH;
						end
						reply.frame_offset = 4'(i);
						reply.last = (i == tail_slot);
						expected_replies.push_back(reply);
						slot_busy[i] = 1'b0;
					end
				end
			end
		end
	endtask

	// Compare one result with the oldest reply still owed
	task automatic check_reply(input out_item_t got);
		out_item_t want;
		if (expected_replies.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing pending", got));
		end else begin
			want = expected_replies.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.accepted !== want.accepted)
				report_mismatch($sformatf("accepted %0d, want %0d", got.accepted, want.accepted));
			if (got.out_status !== want.out_status)
				report_mismatch($sformatf("status %h, want %h", got.out_status, want.out_status));
			if (got.out_first !== want.out_first)
				report_mismatch($sformatf("first %h, want %h", got.out_first, want.out_first));
			if (got.out_second !== want.out_second)
				report_mismatch($sformatf("second %h, want %h", got.out_second, want.out_second));
			if (got.out_length !== want.out_length)
				report_mismatch($sformatf("length %0d, want %0d", got.out_length, want.out_length));
			if (got.frame_offset !== want.frame_offset)
				report_mismatch($sformatf("offset %0d, want %0d", got.frame_offset,
					want.frame_offset));
			if (got.last !== want.last)
				report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
		end
	endtask

	// Retire results before taking new requests seen on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_reply(out_data);
			if (in_valid && !in_stall)
				predict_request(in_data);
			if (psel && penable && pwrite && pready && paddr == CHANNEL_ADDR)
				channel = pwdata[3:0];
			outstanding = expected_replies.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the MIDI message outbox: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import mmo_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 60;
	localparam logic [2:0] CHANNEL_ADDR = {REG_CHANNEL, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int       fail_count;
	int       outstanding;
	int       cycle_count;
	bit       burst;
	bit       hold_wanted;
	in_item_t recent_msgs [4];
	int       recent_pos;

	midi_message_outbox dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mmo_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Give up on a hung run
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Mostly short gaps, some long ones, none while bursting
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 25);
	endfunction

	// Offer one request and hold it until the block takes it
	task automatic send_request(input in_item_t req);
		int idle;
		idle = pick_gap();
		if (idle > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic queue_msg(input logic [7:0] st, input logic [7:0] f, input logic [7:0] s,
			input logic [1:0] len);
		in_item_t req;
		req.operation = OP_QUEUE;
		req.status_byte = st;
		req.first_data = f;
		req.second_data = s;
		req.message_length = len;
		send_request(req);
	endtask

	task automatic drain_all();
		in_item_t    req;
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		req = noise[$bits(in_item_t)-1:0];
		req.operation = OP_DRAIN;
		send_request(req);
	endtask

	// Drop valid and wait until every reply has come back
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Write the channel register; upper data bits carry noise
	task automatic write_channel(input logic [3:0] ch);
		logic [31:0] word;
		word = $urandom;
		word[3:0] = ch;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CHANNEL_ADDR;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Build a queue request, often a repeat of a recent message to hit duplicates
	function automatic in_item_t random_message();
		in_item_t req;
		int r;
		if ($urandom_range(0, 99) < 30) begin
			req = recent_msgs[$urandom_range(0, 3)];
		end else begin
			if ($urandom_range(0, 1))
				req.status_byte = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 3))};
			else
				req.status_byte = 8'($urandom_range(0, 255));
			req.first_data = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(0, 255));
			req.second_data = $urandom_range(0, 1) ? 8'($urandom_range(0, 3))
				: 8'($urandom_range(0, 255));
			r = $urandom_range(0, 99);
			if (r < 45)
				req.message_length = FULL_LENGTH;
			else if (r < 90)
				req.message_length = SHORT_LENGTH;
			else
				req.message_length = 2'($urandom_range(0, 1));
		end
		req.operation = OP_QUEUE;
		return req;
	endfunction

	task automatic run_phase(input int count, input bit pressed);
		in_item_t req;
		burst = pressed;
		hold_wanted = pressed;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 14) begin
				drain_all();
			end else begin
				req = random_message();
				recent_msgs[recent_pos] = req;
				recent_pos = (recent_pos + 1) % 4;
				send_request(req);
			end
		end
		burst = 1'b0;
	endtask

	// Receiver: random stalls, stall-free stretches, and one long hold-off on request
	initial begin
		int len;
		bit val;
		int r;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			r = $urandom_range(0, 9);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				val = 1'b1;
				len = HOLD_CYCLES;
			end else if (r < 4) begin
				val = 1'b0;
				len = $urandom_range(1, 4);
			end else if (r < 6) begin
				val = 1'b0;
				len = $urandom_range(20, 60);
			end else if (r < 9) begin
				val = 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				val = 1'b1;
				len = $urandom_range(8, 30);
			end
			@(negedge clk);
			out_stall <= val;
			repeat (len - 1) @(negedge clk);
		end
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		burst = 1'b0;
		hold_wanted = 1'b0;
		recent_pos = 0;
		for (int i = 0; i < 4; i++)
			recent_msgs[i] = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		write_channel(4'h0);

		// drain of an empty table, then duplicates, odd lengths and field extremes
		drain_all();
		queue_msg(8'h90, 8'h3C, 8'h7F, FULL_LENGTH);
		queue_msg(8'h90, 8'h3C, 8'h7F, FULL_LENGTH);
		queue_msg(8'hC0, 8'h05, 8'hFF, SHORT_LENGTH);
		queue_msg(8'hFF, 8'hFF, 8'hFF, FULL_LENGTH);
		queue_msg(8'h00, 8'h00, 8'h00, SHORT_LENGTH);
		queue_msg(8'h80, 8'h3C, 8'h55, 2'd0);
		queue_msg(8'h80, 8'h3C, 8'hAA, 2'd1);
		// fill the rest of the table
		for (int k = 0; k < 10; k++)
			queue_msg(8'hA0, 8'(k), 8'(8'h40 + k), FULL_LENGTH);
		// full table: a new message is rejected, a duplicate still accepted
		queue_msg(8'hF0, 8'h01, 8'h02, FULL_LENGTH);
		queue_msg(8'hA0, 8'd9, 8'h49, FULL_LENGTH);
		drain_all();
		drain_all();
		settle();

		write_channel(4'hF);
		run_phase(PHASE_ITEMS, 1'b0);
		settle();
		write_channel(4'($urandom_range(1, 14)));
		run_phase(PHASE_ITEMS, 1'b0);
		settle();
		write_channel(4'($urandom_range(0, 15)));
		run_phase(PHASE_ITEMS, 1'b1);
		settle();
		write_channel(4'h0);
		run_phase(PHASE_ITEMS, 1'b0);
		drain_all();
		settle();
		repeat (40) @(negedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
